FILE: rtl/sidi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sidi_pkg
// Shared types and constants for the shifting insert/delete word list.
// ----------------------------------------------------------------------------
package sidi_pkg;

    localparam int WORD_W       = 32;
    localparam int POS_W        = 4;
    localparam int REQ_W        = 3;
    localparam int STATUS_W     = 2;
    localparam int CAPACITY_DEF = 16;

    typedef enum logic [REQ_W-1:0] {
        REQ_APPEND    = 3'd0,
        REQ_READ      = 3'd1,
        REQ_OVERWRITE = 3'd2,
        REQ_INSERT    = 3'd3,
        REQ_DELETE    = 3'd4
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Broadcast to every cell; each cell works out its own move from these.
    typedef struct packed {
        logic load_at_pos;
        logic load_at_count;
        logic shift_up;
        logic shift_down;
    } t_cell_ctl;

endpackage

FILE: rtl/sidi_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sidi_cell
// One storage cell of the list: holds, takes a neighbour's word or the new word.
// ----------------------------------------------------------------------------
module sidi_cell #(
    parameter int CMP_W = 5,
    parameter int IDX   = 0
) (
    input  logic                                i_clk,
    input  sidi_pkg::t_cell_ctl                 i_ctl,
    input  logic [CMP_W-1:0]                    i_pos,
    input  logic [CMP_W-1:0]                    i_count,
    input  logic signed [sidi_pkg::WORD_W-1:0]  i_word,
    input  logic signed [sidi_pkg::WORD_W-1:0]  i_left,
    input  logic signed [sidi_pkg::WORD_W-1:0]  i_right,
    output logic signed [sidi_pkg::WORD_W-1:0]  o_q
);
    import sidi_pkg::*;

    localparam logic [CMP_W-1:0] IDX_V = CMP_W'(IDX);

    logic signed [WORD_W-1:0] r_q;
    logic signed [WORD_W-1:0] n_q;

    // Words above the count carry no meaning, so shifts need no upper bound.
    always_comb begin
        n_q = r_q;
        if (i_ctl.load_at_pos && IDX_V == i_pos) begin
            n_q = i_word;
        end else if (i_ctl.shift_up && IDX_V > i_pos) begin
            n_q = i_left;
        end else if (i_ctl.shift_down && IDX_V >= i_pos) begin
            n_q = i_right;
        end else if (i_ctl.load_at_count && IDX_V == i_count) begin
            n_q = i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule

FILE: rtl/shifting_insert_delete_array.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shifting_insert_delete_array
// Ordered list of signed words with append, read, overwrite, insert, delete.
// ----------------------------------------------------------------------------
// The request channel (i_valid, o_stall) carries a request type, a position
// and a word. Each transaction gives exactly one result transaction on the
// result channel (o_valid, i_stall): the word read, a status and the count of
// words after the request.
// The list is a row of cells; on an insert every cell above the position
// takes its lower neighbour's word and on a delete every cell at or above
// it takes its upper neighbour's, all in the same clock.
// A result appears in the output register in the cycle after its request is
// taken. A new request is taken in every cycle while the output register is
// empty or being emptied, giving one transaction per cycle sustained.
// If the receiver stalls while a result waits, o_stall rises and requests
// are held until that result is taken.
// Reset empties the list (count zero) and clears the output valid flag; the
// cell contents are not cleared, as positions at or beyond the count are
// never read.
// ----------------------------------------------------------------------------
module shifting_insert_delete_array #(
    parameter int CAPACITY = sidi_pkg::CAPACITY_DEF,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [sidi_pkg::REQ_W-1:0]            i_req_type,
    input  logic [sidi_pkg::POS_W-1:0]            i_position,
    input  logic signed [sidi_pkg::WORD_W-1:0]    i_word_in,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic signed [sidi_pkg::WORD_W-1:0]    o_word_out,
    output logic [sidi_pkg::STATUS_W-1:0]         o_status,
    output logic [CNT_W-1:0]                      o_count_now
);
    import sidi_pkg::*;

    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int RD_N  = (CAPACITY < (1 << POS_W)) ? CAPACITY : (1 << POS_W);

    logic                     r_valid;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic signed [WORD_W-1:0] r_word;
    logic signed [WORD_W-1:0] n_word;
    t_status                  r_status;
    t_status                  n_status;

    logic                     accept;
    logic                     in_range;
    logic                     full;
    logic [CMP_W-1:0]         pos_x;
    logic [CMP_W-1:0]         count_x;
    logic signed [WORD_W-1:0] rd_word;
    t_cell_ctl                ctl;
    logic signed [WORD_W-1:0] cell_q [CAPACITY];

    assign o_stall  = r_valid & i_stall;
    assign accept   = i_valid & ~o_stall;
    assign pos_x    = CMP_W'(i_position);
    assign count_x  = CMP_W'(r_count);
    assign in_range = pos_x < count_x;
    assign full     = r_count == CNT_W'(CAPACITY);

    always_comb begin
        rd_word = '0;
        for (int i = 0; i < RD_N; i++) begin
            if (i_position == POS_W'(i)) begin
                rd_word = cell_q[i];
            end
        end
    end

    // Decode: cell controls fire only for a transaction that succeeds.
    always_comb begin
        ctl      = '0;
        n_count  = r_count;
        n_word   = '0;
        n_status = ST_DONE;
        case (t_req'(i_req_type))
            REQ_APPEND: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    ctl.load_at_count = accept;
                    n_count           = r_count + CNT_W'(1);
                end
            end
            REQ_READ: begin
                if (in_range) begin
                    n_word = rd_word;
                end else begin
                    n_status = ST_RANGE;
                end
            end
            REQ_OVERWRITE: begin
                if (in_range) begin
                    ctl.load_at_pos = accept;
                end else begin
                    n_status = ST_RANGE;
                end
            end
            REQ_INSERT: begin
                if (!in_range) begin
                    n_status = ST_RANGE;
                end else if (full) begin
                    n_status = ST_FULL;
                end else begin
                    ctl.load_at_pos = accept;
                    ctl.shift_up    = accept;
                    n_count         = r_count + CNT_W'(1);
                end
            end
            REQ_DELETE: begin
                if (in_range) begin
                    ctl.shift_down = accept;
                    n_count        = r_count - CNT_W'(1);
                end else begin
                    n_status = ST_RANGE;
                end
            end
            default: begin
            end
        endcase
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [WORD_W-1:0] left;
        logic signed [WORD_W-1:0] right;

        if (g == 0) begin : g_first
            assign left = i_word_in;
        end else begin : g_mid_l
            assign left = cell_q[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign right = cell_q[g];
        end else begin : g_mid_r
            assign right = cell_q[g+1];
        end

        sidi_cell #(
            .CMP_W (CMP_W),
            .IDX   (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_pos   (pos_x),
            .i_count (count_x),
            .i_word  (i_word_in),
            .i_left  (left),
            .i_right (right),
            .o_q     (cell_q[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_count <= '0;
        end else begin
            if (accept) begin
                r_valid <= 1'b1;
                r_count <= n_count;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word   <= n_word;
            r_status <= n_status;
        end
    end

    assign o_valid     = r_valid;
    assign o_word_out  = r_word;
    assign o_status    = r_status;
    assign o_count_now = r_count;

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("word count exceeds capacity");

    a_append_grows : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && t_req'(i_req_type) == REQ_APPEND && !full)
        |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("append into a list with room did not grow the count");

    a_error_word_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_status != ST_DONE) |-> (r_word == '0))
        else $error("failed transaction returned a non-zero word");

    a_reject_keeps_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && n_status != ST_DONE) |=> $stable(r_count))
        else $error("rejected transaction changed the count");

endmodule
